// ===== rtl/tkl_pkg.sv =====
// ----------------------------------------------------------------------------
// tkl_pkg
// Shared types and constants for the top-K largest object tracker.
// ----------------------------------------------------------------------------
package tkl_pkg;

  localparam int SIZE_W = 31;
  localparam int ID_W   = 32;
  localparam int RANK_W = 5;

  // Input request as it arrives on the port.
  typedef struct packed {
    logic              req_type;
    logic [SIZE_W-1:0] obj_size;
    logic [ID_W-1:0]   object_id;
  } req_t;

  // One ranked entry of a report.
  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [SIZE_W-1:0] entry_size;
    logic [ID_W-1:0]   entry_id;
    logic              entry_valid;
    logic              last_entry;
  } res_t;

  typedef enum logic {
    OP_OFFER  = 1'b0,
    OP_REPORT = 1'b1
  } op_t;

  // Classified request held in the queue between front and back.
  typedef struct packed {
    op_t               op;
    logic [SIZE_W-1:0] size;
    logic [ID_W-1:0]   id;
  } cmd_t;

  // One heap slot.
  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [ID_W-1:0]   id;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OFF_CMP,
    ST_SORT_RD,
    ST_SORT_X,
    ST_SIFT,
    ST_EMIT_RD,
    ST_EMIT
  } state_t;

endpackage

// ===== rtl/tkl_front.sv =====
// ----------------------------------------------------------------------------
// tkl_front
// Accepts requests, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module tkl_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  tkl_pkg::req_t req,
  output logic          cmd_valid,
  input  logic          cmd_pop,
  output tkl_pkg::cmd_t cmd
);

  tkl_pkg::cmd_t slot [2];
  logic          wp;
  logic          rp;
  logic [1:0]    cnt;
  logic          push;
  tkl_pkg::cmd_t cmd_in;

  assign req_stall = (cnt == 2'd2);
  assign push      = req_valid && !req_stall;
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = slot[rp];

  always_comb begin
    cmd_in.op   = req.req_type ? tkl_pkg::OP_REPORT : tkl_pkg::OP_OFFER;
    cmd_in.size = req.obj_size;
    cmd_in.id   = req.object_id;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wp] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (cmd_pop) begin
        rp <= ~rp;
      end
      case ({push, cmd_pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

// ===== rtl/tkl_engine.sv =====
// ----------------------------------------------------------------------------
// tkl_engine
// Min-heap store and sequencer: offer with sift-down, heapsort report, clear.
// ----------------------------------------------------------------------------
module tkl_engine #(
  parameter int TOP_COUNT = 20
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_pop,
  input  tkl_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_stall,
  output tkl_pkg::res_t res
);

  localparam int IW = $clog2(TOP_COUNT);
  localparam int CW = IW + 2;
  localparam int KW = $clog2(TOP_COUNT + 1);
  localparam int RW = tkl_pkg::RANK_W;

  tkl_pkg::state_t state, state_next;

  tkl_pkg::entry_t mem [TOP_COUNT];
  logic [TOP_COUNT-1:0] valid;

  tkl_pkg::entry_t rd_a_raw, rd_b_raw, rd_a, rd_b;
  logic            rd_a_vld, rd_b_vld;

  logic            rd_en_a, rd_en_b, wr_en;
  logic [IW-1:0]   addr_a, addr_b, wr_addr;
  tkl_pkg::entry_t wr_data;

  tkl_pkg::entry_t v;
  logic [IW-1:0]   pos;
  logic [CW-1:0]   bound;
  logic [KW-1:0]   k;
  logic [IW-1:0]   idx;
  logic            sorting;

  logic [CW-1:0]     left, right, cl, cr;
  logic              l_take, r_take, move;
  logic [tkl_pkg::SIZE_W-1:0] cur;
  logic [IW-1:0]     pick_i;
  tkl_pkg::entry_t   child;
  logic              root_less, out_free, out_load, emit_last, sort_last;

  function automatic logic [IW-1:0] clamp(input logic [CW-1:0] c);
    return (c < CW'(TOP_COUNT)) ? c[IW-1:0] : '0;
  endfunction

  // Entries never written since the last clear read as zero.
  assign rd_a = rd_a_vld ? rd_a_raw : '0;
  assign rd_b = rd_b_vld ? rd_b_raw : '0;

  // Sift-down decision for the carried value v sitting at pos.
  always_comb begin
    left   = CW'({pos, 1'b1});
    right  = left + CW'(1);
    l_take = (left < bound) && (rd_a.size < v.size);
    cur    = l_take ? rd_a.size : v.size;
    r_take = (right < bound) && (rd_b.size < cur);
    move   = l_take || r_take;
    child  = r_take ? rd_b : rd_a;
    pick_i = r_take ? right[IW-1:0] : left[IW-1:0];
    cl     = CW'({pick_i, 1'b1});
    cr     = cl + CW'(1);
  end

  assign root_less = (rd_a.size < v.size);
  assign out_free  = !res_valid || !res_stall;
  assign emit_last = (idx == IW'(TOP_COUNT - 1));
  assign sort_last = (k == KW'(1));

  always_comb begin
    state_next = state;
    unique case (state)
      tkl_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          state_next = (cmd.op == tkl_pkg::OP_REPORT) ? tkl_pkg::ST_SORT_RD
                                                      : tkl_pkg::ST_OFF_CMP;
        end
      end
      tkl_pkg::ST_OFF_CMP: begin
        state_next = root_less ? tkl_pkg::ST_SIFT : tkl_pkg::ST_IDLE;
      end
      tkl_pkg::ST_SORT_RD: state_next = tkl_pkg::ST_SORT_X;
      tkl_pkg::ST_SORT_X:  state_next = tkl_pkg::ST_SIFT;
      tkl_pkg::ST_SIFT: begin
        if (!move) begin
          if (!sorting) begin
            state_next = tkl_pkg::ST_IDLE;
          end else if (sort_last) begin
            state_next = tkl_pkg::ST_EMIT_RD;
          end else begin
            state_next = tkl_pkg::ST_SORT_RD;
          end
        end
      end
      tkl_pkg::ST_EMIT_RD: state_next = tkl_pkg::ST_EMIT;
      tkl_pkg::ST_EMIT: begin
        if (out_free && emit_last) begin
          state_next = tkl_pkg::ST_IDLE;
        end
      end
      default: state_next = tkl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop  = 1'b0;
    rd_en_a  = 1'b0;
    rd_en_b  = 1'b0;
    addr_a   = '0;
    addr_b   = '0;
    wr_en    = 1'b0;
    wr_addr  = '0;
    wr_data  = '0;
    out_load = 1'b0;
    unique case (state)
      tkl_pkg::ST_IDLE: begin
        cmd_pop = cmd_valid;
        rd_en_a = cmd_valid;
      end
      tkl_pkg::ST_OFF_CMP: begin
        if (root_less) begin
          rd_en_a = 1'b1;
          rd_en_b = 1'b1;
          addr_a  = clamp(CW'(1));
          addr_b  = clamp(CW'(2));
        end
      end
      tkl_pkg::ST_SORT_RD: begin
        rd_en_a = 1'b1;
        rd_en_b = 1'b1;
        addr_b  = IW'(k - KW'(1));
      end
      tkl_pkg::ST_SORT_X: begin
        // The old root goes to the end of the shrinking heap.
        wr_en   = 1'b1;
        wr_addr = IW'(k - KW'(1));
        wr_data = rd_a;
        rd_en_a = 1'b1;
        rd_en_b = 1'b1;
        addr_a  = clamp(CW'(1));
        addr_b  = clamp(CW'(2));
      end
      tkl_pkg::ST_SIFT: begin
        wr_en   = 1'b1;
        wr_addr = pos;
        if (move) begin
          wr_data = child;
          rd_en_a = 1'b1;
          rd_en_b = 1'b1;
          addr_a  = clamp(cl);
          addr_b  = clamp(cr);
        end else begin
          wr_data = v;
        end
      end
      tkl_pkg::ST_EMIT_RD: begin
        rd_en_a = 1'b1;
        addr_a  = idx;
      end
      tkl_pkg::ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (!emit_last) begin
            rd_en_a = 1'b1;
            addr_a  = idx + IW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en_a) begin
      rd_a_raw <= mem[addr_a];
      rd_a_vld <= valid[addr_a];
    end
    if (rd_en_b) begin
      rd_b_raw <= mem[addr_b];
      rd_b_vld <= valid[addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (state == tkl_pkg::ST_IDLE && cmd_valid) begin
      v.size  <= cmd.size;
      v.id    <= cmd.id;
      k       <= KW'(TOP_COUNT);
      sorting <= (cmd.op == tkl_pkg::OP_REPORT);
    end
    if (state == tkl_pkg::ST_OFF_CMP) begin
      pos   <= '0;
      bound <= CW'(TOP_COUNT);
    end
    if (state == tkl_pkg::ST_SORT_X) begin
      v     <= rd_b;
      pos   <= '0;
      bound <= CW'(k) - CW'(1);
    end
    if (state == tkl_pkg::ST_SIFT) begin
      if (move) begin
        pos <= pick_i;
      end else if (sorting) begin
        if (sort_last) begin
          idx <= '0;
        end else begin
          k <= k - KW'(1);
        end
      end
    end
    if (out_load) begin
      res.rank        <= RW'({1'b0, idx} + 1'b1);
      res.entry_size  <= rd_a.size;
      res.entry_id    <= rd_a.id;
      res.entry_valid <= (rd_a.size != '0);
      res.last_entry  <= emit_last;
      idx             <= idx + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tkl_pkg::ST_IDLE;
      valid     <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load && emit_last) begin
        valid <= '0;
      end else if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (out_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/top_k_largest_tracker.sv =====
// ----------------------------------------------------------------------------
// top_k_largest_tracker
// Keeps the TOP_COUNT largest objects offered and reports them in order.
// ----------------------------------------------------------------------------
// An offer request replaces the smallest kept entry when its size is strictly
// larger and then sifts down the min-heap, one level per cycle; the root is
// read and compared first, and an offer that is not larger goes back to idle
// without a write.
// A report request heapsorts the store, each pass reading the root and the last
// entry, swapping them and sifting down, then emits TOP_COUNT results in
// descending size at one a cycle while the output is not stalled, and finally
// empties the store. The heap sits in a memory with one write and two
// registered read ports, and the sift-down loop runs through that memory. A
// two-entry request queue lets new requests arrive while the heap is busy.
// ----------------------------------------------------------------------------
module top_k_largest_tracker #(
  parameter int TOP_COUNT = 20
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  tkl_pkg::req_t req,
  output logic          res_valid,
  input  logic          res_stall,
  output tkl_pkg::res_t res
);

  logic          cmd_valid;
  logic          cmd_pop;
  tkl_pkg::cmd_t cmd;

  tkl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd)
  );

  tkl_engine #(
    .TOP_COUNT (TOP_COUNT)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

// ===== bench/tb_top_k_largest_tracker.sv =====
// ----------------------------------------------------------------------------
// tb_top_k_largest_tracker
// Self-checking bench for the top-K largest object tracker.
// ----------------------------------------------------------------------------
// A short table of directed requests comes first. It covers empty reports,
// size-0 offers, the largest size and id, and runs of equal sizes. Random
// rounds follow, each a run of offers closed by a report. Every report is
// predicted (empty ones as all-empty entries, the rest by a heap kept alongside the block) and compared field by field.
// Both sides of the block idle at random, and the output is held off for
// one long stretch so that the request queue fills up.
// ----------------------------------------------------------------------------
module tb_top_k_largest_tracker;
  import tkl_pkg::*;

  localparam int KEEP       = 20;
  localparam int ITEMS      = 460;
  localparam int LONG_HOLD  = 400;
  localparam int SETTLE     = 200;
  localparam int LIMIT      = 30000000;
  localparam int PRINT_CAP  = 40;

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_EMPTY
  } chk_t;

  typedef struct packed {
    op_t               op;
    logic [SIZE_W-1:0] size;
    logic [ID_W-1:0]   id;
    chk_t              chk;
  } step_t;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic res_valid;
  logic res_stall;
  res_t res;

  // Kept entries of the predicted heap and the ranked entries still owed.
  logic [SIZE_W-1:0] kept_size [KEEP];
  logic [ID_W-1:0]   kept_id   [KEEP];
  res_t              ranked_q  [$];

  int  errors = 0;
  int  sent_count = 0;
  int  report_count = 0;
  int  entries_seen = 0;
  bit  tx_idle = 1'b1;
  bit  rx_idle = 1'b1;
  bit  long_hold_due = 1'b0;
  bit  long_hold_done = 1'b0;

  // Empty-report rows carry their result in the check column.
  step_t plan [14] = '{
    '{OP_REPORT, 31'h00000000, 32'h00000000, CHK_EMPTY},
    '{OP_REPORT, 31'h00000000, 32'hFFFFFFFF, CHK_EMPTY},
    '{OP_OFFER,  31'h00000000, 32'hFFFFFFFF, CHK_MODEL},
    '{OP_REPORT, 31'h7FFFFFFF, 32'h00000000, CHK_EMPTY},
    '{OP_OFFER,  31'h7FFFFFFF, 32'hFFFFFFFF, CHK_MODEL},
    '{OP_OFFER,  31'h00000001, 32'h00000000, CHK_MODEL},
    '{OP_OFFER,  31'h00000005, 32'hA5A5A5A5, CHK_MODEL},
    '{OP_OFFER,  31'h00000005, 32'h5A5A5A5A, CHK_MODEL},
    '{OP_OFFER,  31'h00000005, 32'h00000003, CHK_MODEL},
    '{OP_OFFER,  31'h7FFFFFFF, 32'h00000001, CHK_MODEL},
    '{OP_OFFER,  31'h2AAAAAAA, 32'h55555555, CHK_MODEL},
    '{OP_OFFER,  31'h55555555, 32'hAAAAAAAA, CHK_MODEL},
    '{OP_REPORT, 31'h7FFFFFFF, 32'hFFFFFFFF, CHK_MODEL},
    '{OP_REPORT, 31'h00000000, 32'h00000000, CHK_EMPTY}
  };

  top_k_largest_tracker #(.TOP_COUNT(KEEP)) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always #5 clk = ~clk;

  task automatic flag_error(input string what);
    errors++;
    if (errors <= PRINT_CAP) $display("ERROR at %0t: %s", $time, what);
  endtask

  function automatic void swap_slots(input int a, input int b);
    logic [SIZE_W-1:0] s;
    logic [ID_W-1:0]   i;
    s = kept_size[a];
    i = kept_id[a];
    kept_size[a] = kept_size[b];
    kept_id[a]   = kept_id[b];
    kept_size[b] = s;
    kept_id[b]   = i;
  endfunction

  // Equal sizes never move: both child tests are strict.
  function automatic void sift_down(input int start, input int bound);
    int pos;
    int pick;
    pos = start;
    while (pos < bound) begin
      pick = pos;
      if (2 * pos + 1 < bound) begin
        if (kept_size[2 * pos + 1] < kept_size[pos]) pick = 2 * pos + 1;
      end
      if (2 * pos + 2 < bound) begin
        if (kept_size[2 * pos + 2] < kept_size[pick]) pick = 2 * pos + 2;
      end
      if (pick == pos) break;
      swap_slots(pick, pos);
      pos = pick;
    end
  endfunction

  function automatic void track_offer(input logic [SIZE_W-1:0] size,
                                      input logic [ID_W-1:0] id);
    if (kept_size[0] < size) begin
      kept_size[0] = size;
      kept_id[0]   = id;
      sift_down(0, KEEP);
    end
  endfunction

  function automatic void clear_heap();
    for (int k = 0; k < KEEP; k++) begin
      kept_size[k] = '0;
      kept_id[k]   = '0;
    end
  endfunction

  // Heapsort in place, then queue every slot as a ranked entry when asked, and clear the heap.
  function automatic void sort_and_rank(input bit queue_entries);
    res_t e;
    for (int k = KEEP; k > 0; k--) begin
      swap_slots(0, k - 1);
      sift_down(0, k - 1);
    end
    for (int k = 0; k < KEEP; k++) begin
      e.rank        = RANK_W'(k + 1);
      e.entry_size  = kept_size[k];
      e.entry_id    = kept_id[k];
      e.entry_valid = (kept_size[k] != '0);
      e.last_entry  = (k == KEEP - 1);
      if (queue_entries) ranked_q.push_back(e);
    end
    clear_heap();
  endfunction

  function automatic void queue_empty_report();
    res_t e;
    for (int k = 0; k < KEEP; k++) begin
      e = '{rank: RANK_W'(k + 1), entry_size: '0, entry_id: '0,
            entry_valid: 1'b0, last_entry: (k == KEEP - 1)};
      ranked_q.push_back(e);
    end
  endfunction

  // When enabled: mostly back to back, sometimes a short gap, now and then a long gap.
  function automatic int gap_len(input bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Small sizes force ties and frequent replacement; the mixed style
  // brings in zero and the largest size.
  function automatic logic [SIZE_W-1:0] pick_size(input int style);
    logic [31:0] w;
    int r;
    w = $urandom;
    case (style)
      0: begin
        w = $urandom_range(1, 40);
      end
      2: begin
        r = $urandom_range(0, 9);
        if (r == 0) w = '0;
        else if (r == 1) w = 32'h7FFFFFFF;
        else if (r < 6) w = $urandom_range(1, 12);
      end
      default: begin
      end
    endcase
    return w[SIZE_W-1:0];
  endfunction

  task automatic send(input op_t op, input logic [SIZE_W-1:0] size,
                      input logic [ID_W-1:0] id, input chk_t chk);
    req_t r;
    int gap;
    r.req_type  = op;
    r.obj_size  = size;
    r.object_id = id;
    gap = gap_len(tx_idle);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sent_count++;
    if (op == OP_OFFER) begin
      track_offer(size, id);
    end else begin
      report_count++;
      if (chk == CHK_EMPTY) begin
        queue_empty_report();
        sort_and_rank(1'b0);
      end else begin
        sort_and_rank(1'b1);
      end
    end
  endtask

  // Stop offering until every owed entry has come out.
  task automatic wait_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (ranked_q.size() != 0);
  endtask

  task automatic check_entry(input res_t got);
    res_t want;
    if (ranked_q.size() == 0) begin
      flag_error($sformatf("entry rank %0d with nothing owed", got.rank));
    end else begin
      want = ranked_q.pop_front();
      if (got.rank !== want.rank)
        flag_error($sformatf("rank %0d, want %0d", got.rank, want.rank));
      if (got.entry_size !== want.entry_size)
        flag_error($sformatf("rank %0d size %h, want %h", want.rank,
                             got.entry_size, want.entry_size));
      if (got.entry_id !== want.entry_id)
        flag_error($sformatf("rank %0d id %h, want %h", want.rank,
                             got.entry_id, want.entry_id));
      if (got.entry_valid !== want.entry_valid)
        flag_error($sformatf("rank %0d valid %b, want %b", want.rank,
                             got.entry_valid, want.entry_valid));
      if (got.last_entry !== want.last_entry)
        flag_error($sformatf("rank %0d last %b, want %b", want.rank,
                             got.last_entry, want.last_entry));
    end
  endtask

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      entries_seen++;
      check_entry(res);
    end
  end

  // Output side: random stalls, plus one long hold on request.
  initial begin : receiver
    int run;
    res_stall = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold_due) begin
        long_hold_due  = 1'b0;
        long_hold_done = 1'b1;
        res_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        run = gap_len(rx_idle);
        if (run > 0) begin
          res_stall <= 1'b1;
          repeat (run) @(posedge clk);
        end
      end
      res_stall <= 1'b0;
      @(posedge clk);
    end
  end

  initial begin : watchdog
    #(LIMIT);
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    int n;
    int style;
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    clear_heap();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) send(plan[i].op, plan[i].size, plan[i].id, plan[i].chk);
    wait_drained();

    // Hold the output while a report is emitting and keep offering, so the
    // request queue fills and the input stalls.
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    repeat (24) send(OP_OFFER, pick_size(1), $urandom, CHK_MODEL);
    long_hold_due = 1'b1;
    send(OP_REPORT, '0, '0, CHK_MODEL);
    repeat (8) send(OP_OFFER, pick_size(0), $urandom, CHK_MODEL);
    send(OP_REPORT, pick_size(2), $urandom, CHK_MODEL);
    wait_drained();

    while (sent_count < ITEMS) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      style   = $urandom_range(0, 2);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : $urandom_range(15, 45);
      repeat (n) send(OP_OFFER, pick_size(style), $urandom, CHK_MODEL);
      // Report fields carry noise; the block must ignore them.
      send(OP_REPORT, pick_size(2), $urandom, CHK_MODEL);
      if ($urandom_range(0, 9) == 0) send(OP_REPORT, pick_size(1), $urandom, CHK_MODEL);
      if ($urandom_range(0, 3) == 0) wait_drained();
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk);

    $display("Run: %0d requests with %0d reports, %0d ranked entries checked.",
             sent_count, report_count, entries_seen);
    $display("Ties, empty slots, full-store replacement and a %0d-cycle output hold (%0s).",
             LONG_HOLD, long_hold_done ? "done" : "missed");
    if (errors == 0 && long_hold_done) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
